### rtl/mwpa_pkg.sv
// ----------------------------------------------------------------------------
// mwpa_pkg
// Shared types and constants for the moving window position averager.
// ----------------------------------------------------------------------------
`default_nettype none

package mwpa_pkg;

	// Ring store depth, in fixes.
	localparam int MAX_WINDOW = 16;

	// Field widths fixed by the interface.
	localparam int DATA_W  = 16;
	localparam int LEVEL_W = 4;
	localparam int CFG_W   = 5;

	// Derived widths.
	localparam int SLOT_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
	localparam int CNT_W  = $clog2(MAX_WINDOW + 1);
	localparam int SUM_W  = DATA_W + CNT_W;
	localparam int STEP_W = $clog2(SUM_W + 1);

	// Register reset value of the window length.
	localparam logic [CFG_W-1:0] WINDOW_RESET = CFG_W'(16);

	// One position fix as it travels through the queue.
	typedef struct packed {
		logic signed [DATA_W-1:0] x;
		logic signed [DATA_W-1:0] y;
		logic [LEVEL_W-1:0]       level;
	} fix_t;

	// Request into the shared divider.
	typedef struct packed {
		logic                    start;
		logic signed [SUM_W-1:0] dividend;
		logic [CNT_W-1:0]        divisor;
	} div_req_t;

	// Response from the shared divider.
	typedef struct packed {
		logic                     done;
		logic signed [DATA_W-1:0] quot;
	} div_rsp_t;

	// Back end sequencer states.
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RD,
		ST_SUB,
		ST_ADD,
		ST_CHK,
		ST_DX,
		ST_WX,
		ST_DY,
		ST_WY,
		ST_OUT
	} back_state_t;

endpackage

`default_nettype wire

### rtl/mwpa_front.sv
// ----------------------------------------------------------------------------
// mwpa_front
// Input side: takes fix words and holds them in a two-entry queue so the
// back end can work on one fix while the next one is already taken.
// ----------------------------------------------------------------------------
`default_nettype none

module mwpa_front (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  in_valid,
	output logic                                       in_stall,
	input  wire logic signed [mwpa_pkg::DATA_W-1:0]    fix_x,
	input  wire logic signed [mwpa_pkg::DATA_W-1:0]    fix_y,
	input  wire logic [mwpa_pkg::LEVEL_W-1:0]          fix_level,
	output logic                                       q_valid,
	output mwpa_pkg::fix_t                             q_fix,
	input  wire logic                                  q_pop
);

	mwpa_pkg::fix_t ent_q [2];
	logic           wr_ptr_q;
	logic           rd_ptr_q;
	logic [1:0]     cnt_q;
	logic           push;
	logic           pop;

	// Stall only when both entries are taken, so stall never looks at valid.
	assign in_stall = (cnt_q == 2'd2);
	assign push     = in_valid && !in_stall;
	assign q_valid  = (cnt_q != 2'd0);
	assign pop      = q_pop && q_valid;
	assign q_fix    = ent_q[rd_ptr_q];

	// Queue pointers and occupancy.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= !wr_ptr_q;
			if (pop)
				rd_ptr_q <= !rd_ptr_q;
			if (push && !pop)
				cnt_q <= cnt_q + 2'd1;
			else if (pop && !push)
				cnt_q <= cnt_q - 2'd1;
		end
	end

	// Queue payload.
	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q].x     <= fix_x;
			ent_q[wr_ptr_q].y     <= fix_y;
			ent_q[wr_ptr_q].level <= fix_level;
		end
	end

endmodule

`default_nettype wire

### rtl/mwpa_div.sv
// ----------------------------------------------------------------------------
// mwpa_div
// Shared restoring divider: signed running sum by the unsigned fix count,
// one quotient bit per cycle, truncated toward zero.
// ----------------------------------------------------------------------------
`default_nettype none

module mwpa_div (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire mwpa_pkg::div_req_t req,
	output mwpa_pkg::div_rsp_t      rsp
);

	logic                              busy_q;
	logic                              done_q;
	logic [mwpa_pkg::STEP_W-1:0]       cnt_q;
	logic [mwpa_pkg::SUM_W-1:0]        mag_q;
	logic [mwpa_pkg::CNT_W-1:0]        rem_q;
	logic [mwpa_pkg::CNT_W-1:0]        dsr_q;
	logic                              neg_q;
	logic [mwpa_pkg::CNT_W:0]          rem_sh;
	logic [mwpa_pkg::CNT_W:0]          rem_sub;
	logic                              ge;
	logic [mwpa_pkg::CNT_W-1:0]        rem_n;
	logic [mwpa_pkg::SUM_W-1:0]        abs_in;
	logic [mwpa_pkg::SUM_W-1:0]        quot_full;

	// One restoring step: shift in the next dividend bit, subtract if it fits.
	always_comb begin
		rem_sh    = {rem_q, mag_q[mwpa_pkg::SUM_W-1]};
		rem_sub   = rem_sh - {1'b0, dsr_q};
		ge        = (rem_sh >= {1'b0, dsr_q});
		rem_n     = ge ? rem_sub[mwpa_pkg::CNT_W-1:0] : rem_sh[mwpa_pkg::CNT_W-1:0];
		abs_in    = req.dividend[mwpa_pkg::SUM_W-1] ? (-req.dividend) : req.dividend;
		quot_full = neg_q ? (-mag_q) : mag_q;
	end

	assign rsp.done = done_q;
	assign rsp.quot = quot_full[mwpa_pkg::DATA_W-1:0];

	// Step counter and handshake.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= mwpa_pkg::STEP_W'(mwpa_pkg::SUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == mwpa_pkg::STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Dividend magnitude shifts out on top while quotient bits enter below.
	always_ff @(posedge clk) begin
		if (req.start) begin
			mag_q <= abs_in;
			rem_q <= '0;
			dsr_q <= req.divisor;
			neg_q <= req.dividend[mwpa_pkg::SUM_W-1];
		end else if (busy_q) begin
			mag_q <= {mag_q[mwpa_pkg::SUM_W-2:0], ge};
			rem_q <= rem_n;
		end
	end

endmodule

`default_nettype wire

### rtl/mwpa_back.sv
// ----------------------------------------------------------------------------
// mwpa_back
// Back end: ring store of recent fixes, running sums, drop sequencing,
// the two mean divisions and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module mwpa_back (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic [mwpa_pkg::CFG_W-1:0]            win_cfg,
	input  wire logic                                  q_valid,
	input  wire mwpa_pkg::fix_t                        q_fix,
	output logic                                       q_pop,
	output mwpa_pkg::div_req_t                         div_req,
	input  wire mwpa_pkg::div_rsp_t                    div_rsp,
	output logic                                       out_valid,
	input  wire logic                                  out_stall,
	output logic signed [mwpa_pkg::DATA_W-1:0]         mean_x,
	output logic signed [mwpa_pkg::DATA_W-1:0]         mean_y,
	output logic [mwpa_pkg::LEVEL_W-1:0]               level_out
);

	mwpa_pkg::back_state_t state_q;
	mwpa_pkg::back_state_t state_n;

	logic signed [mwpa_pkg::DATA_W-1:0] x_mem [mwpa_pkg::MAX_WINDOW];
	logic signed [mwpa_pkg::DATA_W-1:0] y_mem [mwpa_pkg::MAX_WINDOW];
	logic signed [mwpa_pkg::DATA_W-1:0] rd_x_q;
	logic signed [mwpa_pkg::DATA_W-1:0] rd_y_q;

	mwpa_pkg::fix_t                     cur_q;
	logic signed [mwpa_pkg::SUM_W-1:0]  sum_x_q;
	logic signed [mwpa_pkg::SUM_W-1:0]  sum_y_q;
	logic [mwpa_pkg::CNT_W-1:0]         fill_q;
	logic [mwpa_pkg::SLOT_W-1:0]        oldest_q;
	logic [mwpa_pkg::LEVEL_W-1:0]       level_q;
	logic                               added_q;
	logic signed [mwpa_pkg::DATA_W-1:0] mx_q;
	logic signed [mwpa_pkg::DATA_W-1:0] my_q;

	logic [mwpa_pkg::CNT_W-1:0]         win_eff;
	logic [mwpa_pkg::SLOT_W:0]          slot_sum;
	logic [mwpa_pkg::SLOT_W-1:0]        new_slot;
	logic [mwpa_pkg::SLOT_W-1:0]        oldest_inc;
	logic                               out_load;
	logic                               out_take;

	// Clamp the window length to the range one to the store depth.
	always_comb begin
		if (win_cfg == '0)
			win_eff = mwpa_pkg::CNT_W'(1);
		else if ({{mwpa_pkg::CNT_W{1'b0}}, win_cfg} >
			(mwpa_pkg::CNT_W + mwpa_pkg::CFG_W)'(mwpa_pkg::MAX_WINDOW))
			win_eff = mwpa_pkg::CNT_W'(mwpa_pkg::MAX_WINDOW);
		else
			win_eff = mwpa_pkg::CNT_W'(win_cfg);
	end

	// Ring slot arithmetic: the new fix goes after the stored ones.
	always_comb begin
		slot_sum = {1'b0, oldest_q} + (mwpa_pkg::SLOT_W + 1)'(fill_q);
		if (slot_sum >= (mwpa_pkg::SLOT_W + 1)'(mwpa_pkg::MAX_WINDOW))
			slot_sum = slot_sum - (mwpa_pkg::SLOT_W + 1)'(mwpa_pkg::MAX_WINDOW);
		new_slot = slot_sum[mwpa_pkg::SLOT_W-1:0];
		if (oldest_q == mwpa_pkg::SLOT_W'(mwpa_pkg::MAX_WINDOW - 1))
			oldest_inc = '0;
		else
			oldest_inc = oldest_q + 1'b1;
	end

	assign out_take = out_valid && !out_stall;

	// Sequencer: next state and control strobes.
	always_comb begin
		state_n          = state_q;
		q_pop            = 1'b0;
		out_load         = 1'b0;
		div_req.start    = 1'b0;
		div_req.dividend = sum_x_q;
		div_req.divisor  = fill_q;
		case (state_q)
			mwpa_pkg::ST_IDLE: begin
				if (q_valid) begin
					q_pop = 1'b1;
					if (fill_q == mwpa_pkg::CNT_W'(mwpa_pkg::MAX_WINDOW))
						state_n = mwpa_pkg::ST_RD;
					else
						state_n = mwpa_pkg::ST_ADD;
				end
			end
			mwpa_pkg::ST_RD: begin
				state_n = mwpa_pkg::ST_SUB;
			end
			mwpa_pkg::ST_SUB: begin
				state_n = added_q ? mwpa_pkg::ST_CHK : mwpa_pkg::ST_ADD;
			end
			mwpa_pkg::ST_ADD: begin
				state_n = mwpa_pkg::ST_CHK;
			end
			mwpa_pkg::ST_CHK: begin
				state_n = (fill_q > win_eff) ? mwpa_pkg::ST_RD : mwpa_pkg::ST_DX;
			end
			mwpa_pkg::ST_DX: begin
				div_req.start = 1'b1;
				state_n       = mwpa_pkg::ST_WX;
			end
			mwpa_pkg::ST_WX: begin
				if (div_rsp.done)
					state_n = mwpa_pkg::ST_DY;
			end
			mwpa_pkg::ST_DY: begin
				div_req.start    = 1'b1;
				div_req.dividend = sum_y_q;
				state_n          = mwpa_pkg::ST_WY;
			end
			mwpa_pkg::ST_WY: begin
				if (div_rsp.done)
					state_n = mwpa_pkg::ST_OUT;
			end
			mwpa_pkg::ST_OUT: begin
				if (!out_valid || !out_stall) begin
					out_load = 1'b1;
					state_n  = mwpa_pkg::ST_IDLE;
				end
			end
			default: begin
				state_n = mwpa_pkg::ST_IDLE;
			end
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= mwpa_pkg::ST_IDLE;
		else
			state_q <= state_n;
	end

	// Window bookkeeping: sums, count, oldest slot and newest level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_x_q  <= '0;
			sum_y_q  <= '0;
			fill_q   <= '0;
			oldest_q <= '0;
			level_q  <= '0;
			added_q  <= 1'b0;
		end else begin
			case (state_q)
				mwpa_pkg::ST_IDLE: begin
					added_q <= 1'b0;
				end
				mwpa_pkg::ST_SUB: begin
					sum_x_q  <= sum_x_q - {{(mwpa_pkg::SUM_W - mwpa_pkg::DATA_W){rd_x_q[mwpa_pkg::DATA_W-1]}}, rd_x_q};
					sum_y_q  <= sum_y_q - {{(mwpa_pkg::SUM_W - mwpa_pkg::DATA_W){rd_y_q[mwpa_pkg::DATA_W-1]}}, rd_y_q};
					oldest_q <= oldest_inc;
					fill_q   <= fill_q - 1'b1;
				end
				mwpa_pkg::ST_ADD: begin
					sum_x_q <= sum_x_q + {{(mwpa_pkg::SUM_W - mwpa_pkg::DATA_W){cur_q.x[mwpa_pkg::DATA_W-1]}}, cur_q.x};
					sum_y_q <= sum_y_q + {{(mwpa_pkg::SUM_W - mwpa_pkg::DATA_W){cur_q.y[mwpa_pkg::DATA_W-1]}}, cur_q.y};
					fill_q  <= fill_q + 1'b1;
					level_q <= cur_q.level;
					added_q <= 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	// Current fix, ring store writes and the registered read of the oldest slot.
	always_ff @(posedge clk) begin
		if (q_pop)
			cur_q <= q_fix;
		if (state_q == mwpa_pkg::ST_ADD) begin
			x_mem[new_slot] <= cur_q.x;
			y_mem[new_slot] <= cur_q.y;
		end
		rd_x_q <= x_mem[oldest_q];
		rd_y_q <= y_mem[oldest_q];
	end

	// Quotient capture.
	always_ff @(posedge clk) begin
		if (state_q == mwpa_pkg::ST_WX && div_rsp.done)
			mx_q <= div_rsp.quot;
		if (state_q == mwpa_pkg::ST_WY && div_rsp.done)
			my_q <= div_rsp.quot;
	end

	// Output register: holds a finished word until the far side takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid <= 1'b0;
		else if (out_load)
			out_valid <= 1'b1;
		else if (out_take)
			out_valid <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			mean_x    <= mx_q;
			mean_y    <= my_q;
			level_out <= level_q;
		end
	end

	// The count never exceeds the store depth.
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= mwpa_pkg::CNT_W'(mwpa_pkg::MAX_WINDOW))
		else $error("fill count above store depth");

	// A division starts only with a non-empty window that fits the length.
	a_div_count: assert property (@(posedge clk) disable iff (!arst_n)
		div_req.start |-> (fill_q != '0) && (fill_q <= win_eff))
		else $error("division started with a bad count");

	// Every dispatched fix has been added before its means are computed.
	a_added: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == mwpa_pkg::ST_DX) |-> added_q)
		else $error("division before the fix was added");

	// A drop is taken only when there is something stored to drop.
	a_sub_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == mwpa_pkg::ST_SUB) |-> (fill_q != '0))
		else $error("drop from an empty window");

endmodule

`default_nettype wire

### rtl/moving_window_position_average_core.sv
// ----------------------------------------------------------------------------
// moving_window_position_average_core
// Averages the most recent position fixes over a configurable window.
// ----------------------------------------------------------------------------
// Each accepted fix word (x, y, level) yields one result word with the
// windowed means of x and y, truncated toward zero, and the newest level.
// Fixes are handled one at a time: the back end picks a fix up, drops the
// oldest stored fix first once the ring is full, adds the new fix, drops
// each extra old fix left after the window length was shortened, runs the
// two means in turn through the shared restoring divider and loads the
// result word when the output register is empty or being taken. For each
// mean the divider starts, takes one restoring step per quotient bit and
// hands the quotient back. A two-word input queue and an output register
// let new fixes be taken while a finished result waits. The window length
// register (reset 16, values 0 and above 16 act as 1 and 16) must be written
// only while the block is idle; the block itself does not enforce this.
`default_nettype none

module moving_window_position_average_core (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  in_valid,
	output logic                                       in_stall,
	input  wire logic signed [mwpa_pkg::DATA_W-1:0]    fix_x,
	input  wire logic signed [mwpa_pkg::DATA_W-1:0]    fix_y,
	input  wire logic [mwpa_pkg::LEVEL_W-1:0]          fix_level,
	output logic                                       out_valid,
	input  wire logic                                  out_stall,
	output logic signed [mwpa_pkg::DATA_W-1:0]         mean_x,
	output logic signed [mwpa_pkg::DATA_W-1:0]         mean_y,
	output logic [mwpa_pkg::LEVEL_W-1:0]               level_out,
	input  wire logic                                  cfg_valid,
	output logic                                       cfg_ready,
	input  wire logic [mwpa_pkg::CFG_W-1:0]            window_length
);

	logic [mwpa_pkg::CFG_W-1:0] win_q;
	logic                       q_valid;
	logic                       q_pop;
	mwpa_pkg::fix_t             q_fix;
	mwpa_pkg::div_req_t         div_req;
	mwpa_pkg::div_rsp_t         div_rsp;

	// Window length register; writes are always taken.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			win_q <= mwpa_pkg::WINDOW_RESET;
		else if (cfg_valid && cfg_ready)
			win_q <= window_length;
	end

	// Input queue.
	mwpa_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.fix_x     (fix_x),
		.fix_y     (fix_y),
		.fix_level (fix_level),
		.q_valid   (q_valid),
		.q_fix     (q_fix),
		.q_pop     (q_pop)
	);

	// Window store, sums and sequencing.
	mwpa_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.win_cfg   (win_q),
		.q_valid   (q_valid),
		.q_fix     (q_fix),
		.q_pop     (q_pop),
		.div_req   (div_req),
		.div_rsp   (div_rsp),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.mean_x    (mean_x),
		.mean_y    (mean_y),
		.level_out (level_out)
	);

	// Shared divider for both means.
	mwpa_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

endmodule

`default_nettype wire

### sim/tb_moving_window_position_average_core.sv
// ----------------------------------------------------------------------------
// tb_moving_window_position_average_core
// Self-checking bench for the moving window position averager.
// ----------------------------------------------------------------------------
// A short table of directed fix words and window writes comes first. It covers
// coordinate extremes, the reset window, a zero window, an oversized window,
// a completely full ring, and a window that is shortened while the ring is
// full. Random fixes follow in four idle patterns, with a new window length
// between bursts. Every result word is checked against an in-bench model of
// the ring store and the running sums. A few table rows carry hand-typed
// results instead.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_moving_window_position_average_core;

	localparam int     ITEMS_PER_PHASE = 425;
	localparam int     SETTLE_CYCLES   = 16;
	localparam int     TAIL_CYCLES     = 100;
	localparam longint RUN_LIMIT       = 64'd30_000_000;

	// One result word as the block reports it.
	typedef struct packed {
		logic signed [mwpa_pkg::DATA_W-1:0] x;
		logic signed [mwpa_pkg::DATA_W-1:0] y;
		logic [mwpa_pkg::LEVEL_W-1:0]       level;
	} mean_word_t;

	typedef enum logic {ROW_FIX, ROW_WIN} row_kind_t;

	// One row of the directed table.
	typedef struct {
		row_kind_t                  kind;
		mwpa_pkg::fix_t             fix;
		logic [mwpa_pkg::CFG_W-1:0] win;
		bit                         typed;
		mean_word_t                 word;
	} plan_row_t;

	// Block ports.
	logic                               clk           = 1'b0;
	logic                               arst_n        = 1'b0;
	logic                               in_valid      = 1'b0;
	logic                               in_stall;
	logic signed [mwpa_pkg::DATA_W-1:0] fix_x         = '0;
	logic signed [mwpa_pkg::DATA_W-1:0] fix_y         = '0;
	logic [mwpa_pkg::LEVEL_W-1:0]       fix_level     = '0;
	logic                               out_valid;
	logic                               out_stall     = 1'b0;
	logic signed [mwpa_pkg::DATA_W-1:0] mean_x;
	logic signed [mwpa_pkg::DATA_W-1:0] mean_y;
	logic [mwpa_pkg::LEVEL_W-1:0]       level_out;
	logic                               cfg_valid     = 1'b0;
	logic                               cfg_ready;
	logic [mwpa_pkg::CFG_W-1:0]         window_length = '0;

	// Model of the ring store, the running sums and the window register.
	logic signed [mwpa_pkg::DATA_W-1:0] ring_x [mwpa_pkg::MAX_WINDOW];
	logic signed [mwpa_pkg::DATA_W-1:0] ring_y [mwpa_pkg::MAX_WINDOW];
	int                                 acc_x        = 0;
	int                                 acc_y        = 0;
	int                                 fill         = 0;
	int                                 head         = 0;
	logic [mwpa_pkg::LEVEL_W-1:0]       recent_level = '0;
	logic [mwpa_pkg::CFG_W-1:0]         win_reg      = mwpa_pkg::WINDOW_RESET;

	// Result words still owed by the block, oldest first.
	mean_word_t pending_means[$];
	plan_row_t  plan[$];

	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int err_count      = 0;
	int fixes_sent     = 0;
	int results_seen   = 0;
	int window_writes  = 0;

	moving_window_position_average_core i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.fix_x         (fix_x),
		.fix_y         (fix_y),
		.fix_level     (fix_level),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.mean_x        (mean_x),
		.mean_y        (mean_y),
		.level_out     (level_out),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.window_length (window_length)
	);

	// Free-running clock, period 10.
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Hard stop in case the block hangs.
	initial begin
		#(RUN_LIMIT);
		$display("DONE: errors detected");
		$finish;
	end

	// Removes the oldest fix from the model ring and its sums.
	task automatic drop_oldest_fix();
		acc_x = acc_x - ring_x[head];
		acc_y = acc_y - ring_y[head];
		head  = (head + 1) % mwpa_pkg::MAX_WINDOW;
		fill  = fill - 1;
	endtask

	// Adds one fix to the model and works out the result word it causes.
	task automatic track_fix(input mwpa_pkg::fix_t f, output mean_word_t res);
		int eff;
		int slot;
		eff = int'(win_reg);
		if (eff == 0) begin
			eff = 1;
		end
		if (eff > mwpa_pkg::MAX_WINDOW) begin
			eff = mwpa_pkg::MAX_WINDOW;
		end
		// A full ring gives up its oldest slot to the new fix.
		if (fill >= mwpa_pkg::MAX_WINDOW) begin
			drop_oldest_fix();
		end
		slot         = (head + fill) % mwpa_pkg::MAX_WINDOW;
		ring_x[slot] = f.x;
		ring_y[slot] = f.y;
		acc_x        = acc_x + int'(f.x);
		acc_y        = acc_y + int'(f.y);
		fill         = fill + 1;
		recent_level = f.level;
		// A shortened window sheds every surplus fix at once.
		while (fill > eff) begin
			drop_oldest_fix();
		end
		// Signed int division truncates toward zero.
		res.x     = mwpa_pkg::DATA_W'(acc_x / fill);
		res.y     = mwpa_pkg::DATA_W'(acc_y / fill);
		res.level = recent_level;
	endtask

	// Presents one fix word, holds it until accepted, then records its result.
	task automatic send_fix(input mwpa_pkg::fix_t f, input bit typed,
			input mean_word_t typed_word);
		mean_word_t res;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid  <= 1'b1;
		fix_x     <= f.x;
		fix_y     <= f.y;
		fix_level <= f.level;
		@(posedge clk);
		while (in_stall) begin
			@(posedge clk);
		end
		track_fix(f, res);
		pending_means.push_back(typed ? typed_word : res);
		fixes_sent++;
	endtask

	// Stops sending and waits until every owed result word has come out.
	task automatic settle();
		in_valid <= 1'b0;
		while (pending_means.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Writes the window length register; called only while the block is idle.
	task automatic write_window(input logic [mwpa_pkg::CFG_W-1:0] w);
		cfg_valid     <= 1'b1;
		window_length <= w;
		@(posedge clk);
		while (!cfg_ready) begin
			@(posedge clk);
		end
		cfg_valid <= 1'b0;
		win_reg = w;
		window_writes++;
	endtask

	function automatic plan_row_t fix_row(input int x, input int y, input int lvl);
		plan_row_t r;
		r.kind      = ROW_FIX;
		r.fix.x     = mwpa_pkg::DATA_W'(x);
		r.fix.y     = mwpa_pkg::DATA_W'(y);
		r.fix.level = mwpa_pkg::LEVEL_W'(lvl);
		r.win       = '0;
		r.typed     = 1'b0;
		r.word      = '0;
		return r;
	endfunction

	function automatic plan_row_t typed_row(input int x, input int y, input int lvl,
			input int mx, input int my, input int ml);
		plan_row_t r;
		r            = fix_row(x, y, lvl);
		r.typed      = 1'b1;
		r.word.x     = mwpa_pkg::DATA_W'(mx);
		r.word.y     = mwpa_pkg::DATA_W'(my);
		r.word.level = mwpa_pkg::LEVEL_W'(ml);
		return r;
	endfunction

	function automatic plan_row_t win_row(input int w);
		plan_row_t r;
		r      = fix_row(0, 0, 0);
		r.kind = ROW_WIN;
		r.win  = mwpa_pkg::CFG_W'(w);
		return r;
	endfunction

	// Coordinates lean toward the extremes and values near zero.
	function automatic logic signed [mwpa_pkg::DATA_W-1:0] rand_coord();
		case ($urandom_range(7))
			0: begin
				return 16'sh7fff;
			end
			1: begin
				return 16'sh8000;
			end
			2: begin
				return mwpa_pkg::DATA_W'($urandom_range(16) - 8);
			end
			default: begin
				return mwpa_pkg::DATA_W'($urandom);
			end
		endcase
	endfunction

	// Window lengths lean toward the limits and the out-of-range codes.
	function automatic logic [mwpa_pkg::CFG_W-1:0] pick_window();
		case ($urandom_range(5))
			0: begin
				return mwpa_pkg::CFG_W'(mwpa_pkg::MAX_WINDOW);
			end
			1: begin
				return mwpa_pkg::CFG_W'(1);
			end
			2: begin
				return ($urandom_range(1) == 0) ? mwpa_pkg::CFG_W'(0) :
					mwpa_pkg::CFG_W'($urandom_range(31, 17));
			end
			default: begin
				return mwpa_pkg::CFG_W'($urandom_range(mwpa_pkg::MAX_WINDOW, 1));
			end
		endcase
	endfunction

	// Result side: random stall and comparison with the oldest owed word.
	always @(posedge clk) begin : check_results
		mean_word_t want;
		out_stall <= ($urandom_range(99) < recv_stall_pct);
		if (arst_n && out_valid && !out_stall) begin
			results_seen++;
			if (pending_means.size() == 0) begin
				$error("result word with nothing owed: mean_x %0d mean_y %0d level_out %0d",
					mean_x, mean_y, level_out);
				err_count++;
			end else begin
				want = pending_means.pop_front();
				if (mean_x !== want.x) begin
					$error("mean_x mismatch: expected %0d, got %0d", want.x, mean_x);
					err_count++;
				end
				if (mean_y !== want.y) begin
					$error("mean_y mismatch: expected %0d, got %0d", want.y, mean_y);
					err_count++;
				end
				if (level_out !== want.level) begin
					$error("level_out mismatch: expected %0d, got %0d", want.level, level_out);
					err_count++;
				end
			end
		end
	end

	// Main sequence: reset, directed table, random phases, drain.
	initial begin : run_sequence
		mwpa_pkg::fix_t f;
		int             burst;
		int             phase_count;

		// Reset window, first fix alone, then a pair whose sums truncate to zero.
		plan.push_back(typed_row(32767, -32768, 15, 32767, -32768, 15));
		plan.push_back(typed_row(-32768, 32767, 0, 0, 0, 0));
		plan.push_back(fix_row(-1, -2, 10));
		// Zero window acts as one: the result is the newest fix itself.
		plan.push_back(win_row(0));
		plan.push_back(typed_row(-32768, -32768, 3, -32768, -32768, 3));
		plan.push_back(typed_row(32767, 0, 12, 32767, 0, 12));
		// Oversized window saturates; fill the ring and push two fixes past full.
		plan.push_back(win_row(31));
		plan.push_back(fix_row(32767, 32767, 15));
		plan.push_back(fix_row(32767, 32767, 14));
		plan.push_back(fix_row(-32768, -32768, 0));
		plan.push_back(fix_row(32767, -32768, 1));
		plan.push_back(fix_row(-32768, 32767, 2));
		plan.push_back(fix_row(32767, 32767, 4));
		plan.push_back(fix_row(32767, 32767, 8));
		plan.push_back(fix_row(32767, 32767, 7));
		plan.push_back(fix_row(-32768, -32768, 11));
		plan.push_back(fix_row(-32768, -32768, 13));
		plan.push_back(fix_row(1, -1, 5));
		plan.push_back(fix_row(-1, 1, 6));
		plan.push_back(fix_row(32767, 32767, 9));
		plan.push_back(fix_row(32767, 32767, 15));
		plan.push_back(fix_row(-32768, 32767, 0));
		plan.push_back(fix_row(32767, -32768, 3));
		plan.push_back(fix_row(-7, 7, 12));
		// Shorten the window while the ring is full.
		plan.push_back(win_row(2));
		plan.push_back(fix_row(12345, -12345, 10));

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table, no idling.
		foreach (plan[i]) begin
			if (plan[i].kind == ROW_WIN) begin
				settle();
				write_window(plan[i].win);
			end else begin
				send_fix(plan[i].fix, plan[i].typed, plan[i].word);
			end
		end

		// Random fixes in four idle patterns, new window between bursts.
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin
					send_idle_pct  = 0;
					recv_stall_pct = 0;
				end
				1: begin
					send_idle_pct  = 46;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct  = 0;
					recv_stall_pct = 46;
				end
				default: begin
					send_idle_pct  = 12;
					recv_stall_pct = 12;
				end
			endcase
			phase_count = 0;
			while (phase_count < ITEMS_PER_PHASE) begin
				settle();
				write_window(pick_window());
				burst = $urandom_range(60, 10);
				if (burst > ITEMS_PER_PHASE - phase_count) begin
					burst = ITEMS_PER_PHASE - phase_count;
				end
				repeat (burst) begin
					f.x     = rand_coord();
					f.y     = rand_coord();
					f.level = mwpa_pkg::LEVEL_W'($urandom_range(15));
					send_fix(f, 1'b0, '0);
					phase_count++;
				end
			end
		end

		// Drain and let the block sit idle for a while.
		settle();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (pending_means.size() != 0) begin
			$error("%0d result words never arrived", pending_means.size());
			err_count++;
		end

		$display("Fed %0d fixes and checked %0d result words across %0d window writes,",
			fixes_sent, results_seen, window_writes);
		$display("with no idling, sender gaps, receiver stalls, and both together.");
		if (err_count == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

`default_nettype wire

### sim.f
rtl/mwpa_pkg.sv
rtl/mwpa_front.sv
rtl/mwpa_div.sv
rtl/mwpa_back.sv
rtl/moving_window_position_average_core.sv
sim/tb_moving_window_position_average_core.sv
